// File: rtl/atct_pkg.sv
// Package of shared types and constants for the adaptive thermostat cycle timer.
package atct_pkg;

  // Fixed point of the temperature field.
  localparam int unsigned TempFracBits = 4;
  localparam int unsigned TempW        = 13;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // Counter limits.
  localparam logic [5:0] SecondsLast = 6'd59;
  localparam logic [6:0] MinutesFull = 7'd127;

  // Reset values of the configuration registers.
  localparam logic [7:0] SetpointMinRst = 8'd10;
  localparam logic [7:0] SetpointMaxRst = 8'd65;
  localparam logic [3:0] OnMarginRst    = 4'd1;
  localparam logic [3:0] OffMarginRst   = 4'd1;
  localparam logic [4:0] MinHeatRst     = 5'd3;
  localparam logic [4:0] MinWaitRst     = 5'd3;
  localparam logic [6:0] MaxWaitRst     = 7'd103;
  localparam logic [6:0] IdleWaitRst    = 7'd15;

  // Reset value of the adaptive wait limit: min wait plus min heat.
  localparam logic [6:0] WaitLimitRst = 7'd6;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SETPOINT_MIN = 3'd0,
    CFG_SETPOINT_MAX = 3'd1,
    CFG_ON_MARGIN    = 3'd2,
    CFG_OFF_MARGIN   = 3'd3,
    CFG_MIN_HEAT     = 3'd4,
    CFG_MIN_WAIT     = 3'd5,
    CFG_MAX_WAIT     = 3'd6,
    CFG_IDLE_WAIT    = 3'd7
  } cfg_reg_e;

  // Configuration register set.
  typedef struct packed {
    logic [7:0] setpoint_min;
    logic [7:0] setpoint_max;
    logic [3:0] on_margin;
    logic [3:0] off_margin;
    logic [4:0] min_heat_minutes;
    logic [4:0] min_wait_minutes;
    logic [6:0] max_wait_minutes;
    logic [6:0] idle_wait_minutes;
  } cfg_t;

  // One input word.
  typedef struct packed {
    logic              start_preheat;
    logic              mains_on;
    logic              heat_enabled;
    logic              adc_ready;
    logic              heat_locked;
    logic              fault_override;
    logic [7:0]        knob_setting;
    logic [TempW-1:0]  temperature;
    logic              second_tick;
    logic              fan_hold_clear;
  } in_t;

  // Controller state carried from one evaluation to the next.
  typedef struct packed {
    logic       heat_request;
    logic       fan_hold;
    logic       forced_burst;
    logic [6:0] wait_limit;
    logic [6:0] off_minute_count;
    logic [5:0] second_count;
  } state_t;

  // One result word.
  typedef struct packed {
    logic       heater_on;
    logic       fan_on;
    logic [6:0] wait_limit_minutes;
    logic [6:0] off_minutes;
  } out_t;

endpackage

// File: rtl/atct_if.sv
// Channel interfaces of the adaptive thermostat cycle timer: input, result and configuration.
interface atct_in_if;
  logic                             valid;
  logic                             ready;
  logic                             start_preheat;
  logic                             mains_on;
  logic                             heat_enabled;
  logic                             adc_ready;
  logic                             heat_locked;
  logic                             fault_override;
  logic [7:0]                       knob_setting;
  logic signed [atct_pkg::TempW-1:0] temperature;
  logic                             second_tick;
  logic                             fan_hold_clear;

  modport source (
    output valid, start_preheat, mains_on, heat_enabled, adc_ready, heat_locked,
           fault_override, knob_setting, temperature, second_tick, fan_hold_clear,
    input  ready
  );
  modport sink (
    input  valid, start_preheat, mains_on, heat_enabled, adc_ready, heat_locked,
           fault_override, knob_setting, temperature, second_tick, fan_hold_clear,
    output ready
  );
endinterface

interface atct_out_if;
  logic       valid;
  logic       ready;
  logic       heater_on;
  logic       fan_on;
  logic [6:0] wait_limit_minutes;
  logic [6:0] off_minutes;

  modport source (
    output valid, heater_on, fan_on, wait_limit_minutes, off_minutes,
    input  ready
  );
  modport sink (
    input  valid, heater_on, fan_on, wait_limit_minutes, off_minutes,
    output ready
  );
endinterface

interface atct_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [atct_pkg::CfgIdxW-1:0]  index;
  logic [atct_pkg::CfgDataW-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// File: rtl/atct_cfg_regs.sv
// Configuration register file of the adaptive thermostat cycle timer.
module atct_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [atct_pkg::CfgIdxW-1:0]  wr_index_i,
  input  logic [atct_pkg::CfgDataW-1:0] wr_data_i,
  output atct_pkg::cfg_t                cfg_o
);

  atct_pkg::cfg_t cfg_q;
  atct_pkg::cfg_t cfg_d;

  // Decode a write into the addressed register, keeping its own width.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (atct_pkg::cfg_reg_e'(wr_index_i))
        atct_pkg::CFG_SETPOINT_MIN: cfg_d.setpoint_min      = wr_data_i;
        atct_pkg::CFG_SETPOINT_MAX: cfg_d.setpoint_max      = wr_data_i;
        atct_pkg::CFG_ON_MARGIN:    cfg_d.on_margin         = wr_data_i[3:0];
        atct_pkg::CFG_OFF_MARGIN:   cfg_d.off_margin        = wr_data_i[3:0];
        atct_pkg::CFG_MIN_HEAT:     cfg_d.min_heat_minutes  = wr_data_i[4:0];
        atct_pkg::CFG_MIN_WAIT:     cfg_d.min_wait_minutes  = wr_data_i[4:0];
        atct_pkg::CFG_MAX_WAIT:     cfg_d.max_wait_minutes  = wr_data_i[6:0];
        atct_pkg::CFG_IDLE_WAIT:    cfg_d.idle_wait_minutes = wr_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Register bank with its documented reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint_min      <= atct_pkg::SetpointMinRst;
      cfg_q.setpoint_max      <= atct_pkg::SetpointMaxRst;
      cfg_q.on_margin         <= atct_pkg::OnMarginRst;
      cfg_q.off_margin        <= atct_pkg::OffMarginRst;
      cfg_q.min_heat_minutes  <= atct_pkg::MinHeatRst;
      cfg_q.min_wait_minutes  <= atct_pkg::MinWaitRst;
      cfg_q.max_wait_minutes  <= atct_pkg::MaxWaitRst;
      cfg_q.idle_wait_minutes <= atct_pkg::IdleWaitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/atct_eval.sv
// Next-state logic of one thermostat evaluation: setpoint clamp, hysteresis and wait adaptation.
module atct_eval #(
  parameter int unsigned TEMP_FRAC_BITS = atct_pkg::TempFracBits
) (
  input  atct_pkg::cfg_t   cfg_i,
  input  atct_pkg::in_t    word_i,
  input  atct_pkg::state_t state_i,
  output atct_pkg::state_t state_o,
  output atct_pkg::out_t   result_o
);

  // Signed compare width: scaled setpoint or temperature plus a scaled margin.
  localparam int unsigned SpW  = 8 + TEMP_FRAC_BITS;
  localparam int unsigned CmpW = ((SpW > atct_pkg::TempW) ? SpW : atct_pkg::TempW) + 2;

  logic [7:0]             sp;
  logic signed [CmpW-1:0] spf;
  logic signed [CmpW-1:0] temp_ext;
  logic signed [CmpW-1:0] on_thr;
  logic signed [CmpW-1:0] off_thr;
  logic [5:0]             hw;

  // Setpoint clamp and scaled thresholds.
  always_comb begin
    if (word_i.knob_setting < cfg_i.setpoint_min) begin
      sp = cfg_i.setpoint_min;
    end else if (word_i.knob_setting > cfg_i.setpoint_max) begin
      sp = cfg_i.setpoint_max;
    end else begin
      sp = word_i.knob_setting;
    end
    spf      = signed'(CmpW'({sp, {TEMP_FRAC_BITS{1'b0}}}));
    temp_ext = CmpW'(signed'(word_i.temperature));
    on_thr   = temp_ext + signed'(CmpW'({cfg_i.on_margin, {TEMP_FRAC_BITS{1'b0}}}));
    off_thr  = temp_ext - signed'(CmpW'({cfg_i.off_margin, {TEMP_FRAC_BITS{1'b0}}}));
    hw       = {1'b0, cfg_i.min_wait_minutes} + {1'b0, cfg_i.min_heat_minutes};
  end

  // Sequential decision chain of one evaluation.
  always_comb begin
    atct_pkg::state_t s;
    logic             skip;
    logic [7:0]       off_plus_heat;
    logic [7:0]       grown;
    logic [6:0]       tf;

    s             = state_i;
    skip          = 1'b0;
    off_plus_heat = '0;
    grown         = '0;
    tf            = '0;

    // Preheat preset comes first.
    if (word_i.start_preheat) begin
      s.heat_request     = 1'b1;
      s.forced_burst     = 1'b1;
      s.wait_limit       = {2'b00, cfg_i.min_wait_minutes};
      s.off_minute_count = (cfg_i.min_wait_minutes > cfg_i.min_heat_minutes)
                         ? {2'b00, cfg_i.min_wait_minutes - cfg_i.min_heat_minutes} : 7'd0;
      s.second_count     = '0;
    end
    if (word_i.fan_hold_clear) begin
      s.fan_hold = 1'b0;
    end

    if (!word_i.mains_on || !word_i.heat_enabled || !word_i.adc_ready || word_i.heat_locked) begin
      s.heat_request = 1'b0;
    end else if (word_i.fault_override) begin
      s.heat_request = 1'b1;
    end else if (spf >= on_thr) begin
      // Real heating demand.
      if (!s.heat_request) begin
        s.heat_request = 1'b1;
        s.wait_limit   = {1'b0, hw};
      end
      if (s.forced_burst) begin
        // A forced burst cut short shrinks the wait limit.
        s.forced_burst = 1'b0;
        off_plus_heat  = {1'b0, s.off_minute_count} + {3'b000, cfg_i.min_heat_minutes};
        if (off_plus_heat >= {1'b0, s.wait_limit}) begin
          tf = (s.wait_limit > {2'b00, cfg_i.min_heat_minutes})
             ? s.wait_limit - {2'b00, cfg_i.min_heat_minutes} : 7'd0;
          if (tf <= {1'b0, hw}) begin
            tf = {1'b0, hw};
          end
          s.wait_limit = tf;
        end
      end
      s.off_minute_count = '0;
      s.second_count     = '0;
    end else begin
      if (spf <= off_thr) begin
        if (s.heat_request && !s.forced_burst) begin
          s.heat_request = 1'b0;
          if (s.wait_limit <= {2'b00, cfg_i.min_wait_minutes}) begin
            s.wait_limit = {1'b0, hw};
          end
        end
      end else if (s.heat_request) begin
        skip = !s.forced_burst;
      end else begin
        s.wait_limit = cfg_i.idle_wait_minutes;
      end

      if (!skip) begin
        // Off-time counting in seconds and minutes.
        if (!s.heat_request && s.fan_hold) begin
          s.second_count     = '0;
          s.off_minute_count = '0;
        end else if (word_i.second_tick) begin
          if (s.second_count >= atct_pkg::SecondsLast) begin
            s.second_count = '0;
            if (s.off_minute_count < atct_pkg::MinutesFull) begin
              s.off_minute_count = s.off_minute_count + 7'd1;
            end
          end else begin
            s.second_count = s.second_count + 6'd1;
          end
        end
        // Forced burst start, or growth of the limit once it is reached.
        off_plus_heat = {1'b0, s.off_minute_count} + {3'b000, cfg_i.min_heat_minutes};
        if (off_plus_heat >= {1'b0, s.wait_limit}) begin
          s.forced_burst = 1'b1;
          s.heat_request = 1'b1;
          if (s.off_minute_count >= s.wait_limit) begin
            grown = {1'b0, s.wait_limit} + {3'b000, cfg_i.min_heat_minutes};
            if (grown >= {1'b0, cfg_i.max_wait_minutes}) begin
              s.wait_limit = cfg_i.max_wait_minutes;
            end else begin
              s.wait_limit = grown[6:0];
            end
            s.heat_request     = 1'b0;
            s.forced_burst     = 1'b0;
            s.off_minute_count = '0;
            s.second_count     = '0;
          end
        end
      end
    end

    // The fan follows the heater and then holds.
    if (s.heat_request) begin
      s.fan_hold = 1'b1;
    end

    state_o                     = s;
    result_o.heater_on          = s.heat_request;
    result_o.fan_on             = s.heat_request | s.fan_hold;
    result_o.wait_limit_minutes = s.wait_limit;
    result_o.off_minutes        = s.off_minute_count;
  end

endmodule

// File: rtl/adaptive_thermostat_cycle_timer.sv
// Top level of the adaptive thermostat cycle timer: input stage, state, result register.
//
//  channel  | dir  | accepted when          | word
//  ---------+------+------------------------+----------------------------------------
//  in_i     | in   | valid & ready          | flags, knob, temperature, tick, clear
//  out_o    | out  | valid & ready          | heater, fan, wait limit, off minutes
//  cfg_i    | in   | valid & ready (always) | register index, write data
//
// One word per cycle while out_o drains; the word is registered, then its result is registered.
// The input register feeds one pass of evaluation logic that updates the controller
// state and loads the result register at the same edge, so the next word sees the new state.
// A stalled result holds the input stage, which holds its word until the result drains.
// Reset loads state and config reset values and clears both valid flags; no clearing pass.
module adaptive_thermostat_cycle_timer #(
  parameter int unsigned TEMP_FRAC_BITS = atct_pkg::TempFracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  atct_in_if.sink     in_i,
  atct_out_if.source  out_o,
  atct_cfg_if.sink    cfg_i
);

  atct_pkg::cfg_t   cfg;
  atct_pkg::in_t    in_word;
  atct_pkg::in_t    in_q;
  logic             in_v_q;
  atct_pkg::state_t state_q;
  atct_pkg::state_t state_d;
  atct_pkg::out_t   out_q;
  atct_pkg::out_t   out_d;
  logic             out_v_q;
  logic             advance;

  // Configuration registers; writes are always taken.
  assign cfg_i.ready = 1'b1;

  atct_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  // Pack the input word.
  always_comb begin
    in_word.start_preheat  = in_i.start_preheat;
    in_word.mains_on       = in_i.mains_on;
    in_word.heat_enabled   = in_i.heat_enabled;
    in_word.adc_ready      = in_i.adc_ready;
    in_word.heat_locked    = in_i.heat_locked;
    in_word.fault_override = in_i.fault_override;
    in_word.knob_setting   = in_i.knob_setting;
    in_word.temperature    = in_i.temperature;
    in_word.second_tick    = in_i.second_tick;
    in_word.fan_hold_clear = in_i.fan_hold_clear;
  end

  // The held word moves on when the result register is free or draining.
  assign advance    = !out_v_q || out_o.ready;
  assign in_i.ready = !in_v_q || advance;

  atct_eval #(
    .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
  ) u_eval (
    .cfg_i    (cfg),
    .word_i   (in_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (out_d)
  );

  // Input stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_word;
    end
  end

  // Controller state, updated once per evaluated word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.heat_request     <= 1'b0;
      state_q.fan_hold         <= 1'b0;
      state_q.forced_burst     <= 1'b0;
      state_q.wait_limit       <= atct_pkg::WaitLimitRst;
      state_q.off_minute_count <= '0;
      state_q.second_count     <= '0;
    end else if (in_v_q && advance) begin
      state_q <= state_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= in_v_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (in_v_q && advance) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid              = out_v_q;
  assign out_o.heater_on          = out_q.heater_on;
  assign out_o.fan_on             = out_q.fan_on;
  assign out_o.wait_limit_minutes = out_q.wait_limit_minutes;
  assign out_o.off_minutes        = out_q.off_minutes;

endmodule
